@@ sv/three_gaussian_mixture_eval_assert.svh @@
// Assertion macros shared by the mixture evaluator RTL.
`ifndef THREE_GAUSSIAN_MIXTURE_EVAL_ASSERT_SVH
`define THREE_GAUSSIAN_MIXTURE_EVAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGME_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TGME_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/tgme_pkg.sv @@
// Types and constants of the three-Gaussian mixture evaluator.
`default_nettype none
package tgme_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int SAMPLE_W     = 32;
   localparam int WIDTH_W      = 31;
   localparam int WEIGHT_W     = 17;
   localparam int DENS_W       = FRAC_BITS + 1;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   localparam int DIFF_W       = SAMPLE_W + 1;
   localparam int RANGE_SH     = 3;
   localparam int QUOT_W       = FRAC_BITS + RANGE_SH;
   localparam int REM_W        = WIDTH_W;
   localparam int EXP_W        = 2 * QUOT_W - (FRAC_BITS + 1);
   localparam int Q_SH         = 31;
   localparam int Y_SHIFT      = Q_SH - FRAC_BITS - 7;
   localparam int Y_W          = EXP_W + Y_SHIFT;
   localparam int T_W          = 32;
   localparam int PROD_W       = Y_W + T_W;
   localparam int V_W          = PROD_W - Q_SH;
   localparam int RECIP_W      = 32;
   localparam int MPROD_W      = V_W + RECIP_W;
   localparam int HORNER_TERMS = 6;
   localparam int SQUARINGS    = 7;
   localparam int TERM_STAGES  = 1 + QUOT_W + 2 + 3 * (HORNER_TERMS - 1) + 2 + SQUARINGS + 1;

   localparam int MIX_W        = WEIGHT_W + DENS_W - 1;
   localparam int SUM_W        = MIX_W + 2;
   localparam int W_SH         = 16;

   localparam logic [T_W-1:0]      Q31_ONE    = T_W'(64'd1 << Q_SH);
   localparam logic [T_W-1:0]      EXP_RND    = T_W'(64'd1 << (Q_SH - 1 - FRAC_BITS));
   localparam logic [EXP_W-1:0]    EXP_LIMIT  = EXP_W'(64'd16 << FRAC_BITS);
   localparam logic [DENS_W-1:0]   DENS_ONE   = DENS_W'(64'd1 << FRAC_BITS);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(64'd1 << W_SH);
   localparam logic [SUM_W-1:0]    MIX_RND    = SUM_W'(64'd1 << (W_SH - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_A = 3'd0,
      REG_WIDTH_A  = 3'd1,
      REG_CENTER_B = 3'd2,
      REG_WIDTH_B  = 3'd3,
      REG_WIDTH_C  = 3'd4,
      REG_WEIGHT_B = 3'd5,
      REG_WEIGHT_C = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] center;
      logic [WIDTH_W-1:0]         width;
   } term_cfg_type;

   // Truncated reciprocal 2^32/k used for the constant divisions of the series.
   function automatic logic [RECIP_W-1:0] recip(input int k);
      logic [RECIP_W-1:0] r;
      case (k)
         2:       r = 32'h8000_0000;
         3:       r = 32'h5555_5555;
         4:       r = 32'h4000_0000;
         5:       r = 32'h3333_3333;
         6:       r = 32'h2AAA_AAAA;
         default: r = '1;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/tgme_req_if.sv @@
// Sample channel interface of the mixture evaluator.
`default_nettype none
interface tgme_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [tgme_pkg::SAMPLE_W-1:0]   sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ sv/tgme_rsp_if.sv @@
// Density channel interface of the mixture evaluator.
`default_nettype none
interface tgme_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tgme_pkg::DENS_W-1:0]   density;
   modport source (output valid, output density, input ready);
   modport sink (input valid, input density, output ready);
endinterface
`default_nettype wire

@@ sv/tgme_term.sv @@
// Pipelined evaluation of one Gaussian term exp(-d^2/(2*s^2)) in fixed point.
`default_nettype none
module tgme_term (
   input  wire logic                                 clock,
   input  wire logic                                 adv,
   input  wire logic signed [tgme_pkg::SAMPLE_W-1:0] sample,
   input  wire tgme_pkg::term_cfg_type               cfg,
   output logic [tgme_pkg::DENS_W-1:0]               term
);

   localparam int QW = tgme_pkg::QUOT_W;
   localparam int HT = tgme_pkg::HORNER_TERMS;
   localparam int SQ = tgme_pkg::SQUARINGS;

   logic [tgme_pkg::WIDTH_W-1:0]        divisor;
   logic signed [tgme_pkg::DIFF_W-1:0]  diff_in;
   logic [tgme_pkg::DIFF_W-1:0]         mag_in;
   logic                                over_in;

   logic [tgme_pkg::REM_W-1:0]    rem_ff  [0:QW-1];
   logic [QW-1:0]                 q_ff    [0:QW];
   logic [tgme_pkg::RANGE_SH-1:0] lo_ff   [0:QW-1];
   logic                          dkill_ff[0:QW];

   logic [2*QW-1:0]               qsq_ff;
   logic                          sqkill_ff;
   logic [tgme_pkg::EXP_W-1:0]    e_in;
   logic [tgme_pkg::Y_W-1:0]      y_ff;
   logic                          ykill_ff;

   logic [tgme_pkg::PROD_W-1:0]   a_prod_ff[0:HT-1];
   logic [tgme_pkg::Y_W-1:0]      a_y_ff   [0:HT-2];
   logic                          a_kill_ff[0:HT-1];
   logic [tgme_pkg::V_W-1:0]      b_v_ff   [0:HT-2];
   logic [tgme_pkg::MPROD_W-1:0]  b_m_ff   [0:HT-2];
   logic [tgme_pkg::Y_W-1:0]      b_y_ff   [0:HT-2];
   logic                          b_kill_ff[0:HT-2];
   logic [tgme_pkg::T_W-1:0]      c_t_ff   [0:HT-1];
   logic [tgme_pkg::Y_W-1:0]      c_y_ff   [0:HT-2];
   logic                          c_kill_ff[0:HT-1];

   logic [tgme_pkg::T_W-1:0]      sq_ff    [0:SQ-1];
   logic                          sk_ff    [0:SQ-1];
   logic [tgme_pkg::DENS_W-1:0]   term_ff;

   assign divisor = (cfg.width == '0) ? tgme_pkg::WIDTH_W'(1) : cfg.width;
   assign diff_in = tgme_pkg::DIFF_W'(sample) - tgme_pkg::DIFF_W'(cfg.center);
   assign mag_in  = diff_in[tgme_pkg::DIFF_W-1] ? tgme_pkg::DIFF_W'(-diff_in)
                                                : tgme_pkg::DIFF_W'(diff_in);
   assign over_in = {1'b0, mag_in} >= {divisor, {tgme_pkg::RANGE_SH{1'b0}}};

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]   <= tgme_pkg::REM_W'(mag_in[tgme_pkg::DIFF_W-1:tgme_pkg::RANGE_SH]);
         lo_ff[0]    <= mag_in[tgme_pkg::RANGE_SH-1:0];
         q_ff[0]     <= '0;
         dkill_ff[0] <= over_in;
      end
   end

   // Restoring divider, one quotient bit per stage.
   for (genvar i = 0; i < QW; i++) begin : g_div
      localparam int BIT = QW - 1 - i;
      logic                        nb;
      logic [tgme_pkg::REM_W:0]    trial;
      logic                        ge;
      if (BIT >= tgme_pkg::FRAC_BITS) begin : g_lo
         assign nb = lo_ff[i][BIT-tgme_pkg::FRAC_BITS];
      end else begin : g_zero
         assign nb = 1'b0;
      end
      assign trial = {rem_ff[i], nb};
      assign ge    = trial >= (tgme_pkg::REM_W+1)'(divisor);
      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[i+1]     <= {q_ff[i][QW-2:0], ge};
            dkill_ff[i+1] <= dkill_ff[i];
         end
      end
      if (i < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i+1] <= ge ? tgme_pkg::REM_W'(trial - (tgme_pkg::REM_W+1)'(divisor))
                                 : tgme_pkg::REM_W'(trial);
               lo_ff[i+1]  <= lo_ff[i];
            end
         end
      end
   end

   assign e_in = qsq_ff[2*QW-1:tgme_pkg::FRAC_BITS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         qsq_ff    <= (2*QW)'(q_ff[QW]) * (2*QW)'(q_ff[QW]);
         sqkill_ff <= dkill_ff[QW];
         y_ff      <= tgme_pkg::Y_W'(e_in) << tgme_pkg::Y_SHIFT;
         ykill_ff  <= sqkill_ff || (e_in > tgme_pkg::EXP_LIMIT);
      end
   end

   // Horner series of exp(-y), three stages per coefficient; the last (k = 1) has no division stage.
   for (genvar h = 0; h < HT; h++) begin : g_horner
      localparam int K = HT - h;
      logic [tgme_pkg::Y_W-1:0] y_src;
      logic [tgme_pkg::T_W-1:0] t_src;
      logic                     kill_src;
      logic [tgme_pkg::V_W-1:0] v;
      if (h == 0) begin : g_first
         assign y_src    = y_ff;
         assign t_src    = tgme_pkg::Q31_ONE;
         assign kill_src = ykill_ff;
      end else begin : g_next
         assign y_src    = c_y_ff[h-1];
         assign t_src    = c_t_ff[h-1];
         assign kill_src = c_kill_ff[h-1];
      end
      assign v = a_prod_ff[h][tgme_pkg::PROD_W-1:tgme_pkg::Q_SH];
      always_ff @(posedge clock) begin
         if (adv) begin
            a_prod_ff[h] <= tgme_pkg::PROD_W'(y_src) * tgme_pkg::PROD_W'(t_src);
            a_kill_ff[h] <= kill_src;
         end
      end
      if (K > 1) begin : g_div_k
         logic [tgme_pkg::V_W-1:0]   qe;
         logic [tgme_pkg::V_W+2:0]   kk;
         logic [tgme_pkg::V_W+2:0]   r;
         logic [tgme_pkg::V_W-1:0]   qc;
         assign qe = b_m_ff[h][tgme_pkg::MPROD_W-1:tgme_pkg::RECIP_W];
         assign kk = (tgme_pkg::V_W+3)'(K);
         assign r  = (tgme_pkg::V_W+3)'(b_v_ff[h]) - (tgme_pkg::V_W+3)'(qe) * kk;
         assign qc = qe + tgme_pkg::V_W'(r >= kk);
         always_ff @(posedge clock) begin
            if (adv) begin
               a_y_ff[h]    <= y_src;
               b_v_ff[h]    <= v;
               b_m_ff[h]    <= tgme_pkg::MPROD_W'(v) * tgme_pkg::MPROD_W'(tgme_pkg::recip(K));
               b_y_ff[h]    <= a_y_ff[h];
               b_kill_ff[h] <= a_kill_ff[h];
               c_t_ff[h]    <= tgme_pkg::Q31_ONE - tgme_pkg::T_W'(qc);
               c_y_ff[h]    <= b_y_ff[h];
               c_kill_ff[h] <= b_kill_ff[h];
            end
         end
      end else begin : g_unit
         always_ff @(posedge clock) begin
            if (adv) begin
               c_t_ff[h]    <= tgme_pkg::Q31_ONE - tgme_pkg::T_W'(v);
               c_kill_ff[h] <= a_kill_ff[h];
            end
         end
      end
   end

   // Seven squarings raise the series result to the power 128.
   for (genvar j = 0; j < SQ; j++) begin : g_sq
      logic [tgme_pkg::T_W-1:0]   src;
      logic                       ksrc;
      logic [2*tgme_pkg::T_W-1:0] p;
      if (j == 0) begin : g_first
         assign src  = c_t_ff[HT-1];
         assign ksrc = c_kill_ff[HT-1];
      end else begin : g_next
         assign src  = sq_ff[j-1];
         assign ksrc = sk_ff[j-1];
      end
      assign p = (2*tgme_pkg::T_W)'(src) * (2*tgme_pkg::T_W)'(src);
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[j] <= p[tgme_pkg::Q_SH+tgme_pkg::T_W-1:tgme_pkg::Q_SH];
            sk_ff[j] <= ksrc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         term_ff <= sk_ff[SQ-1] ? '0
                    : tgme_pkg::DENS_W'((sq_ff[SQ-1] + tgme_pkg::EXP_RND)
                                        >> (tgme_pkg::Q_SH - tgme_pkg::FRAC_BITS));
      end
   end

   assign term = term_ff;

endmodule
`default_nettype wire

@@ sv/three_gaussian_mixture_eval.sv @@
// A sample runs through the term pipelines, product registers and output register.
// Throughput: one transaction per cycle when not stalled; the 19-stage divider
// and six-step series with seven squarings are fully pipelined per component.
// Reset clears all valid bits, the output valid included, and loads the
// registers with centers 0, widths one and weights 0.
`default_nettype none
module three_gaussian_mixture_eval (
   input  wire logic                               clock,
   input  wire logic                               reset,
   tgme_req_if.sink                                req_if,
   tgme_rsp_if.source                              rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [tgme_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tgme_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   `include "three_gaussian_mixture_eval_assert.svh"

   localparam int LAST = tgme_pkg::TERM_STAGES;

   logic signed [tgme_pkg::SAMPLE_W-1:0] center_a_ff;
   logic signed [tgme_pkg::SAMPLE_W-1:0] center_b_ff;
   logic [tgme_pkg::WIDTH_W-1:0]         width_a_ff;
   logic [tgme_pkg::WIDTH_W-1:0]         width_b_ff;
   logic [tgme_pkg::WIDTH_W-1:0]         width_c_ff;
   logic [tgme_pkg::WEIGHT_W-1:0]        weight_b_ff;
   logic [tgme_pkg::WEIGHT_W-1:0]        weight_c_ff;

   logic [tgme_pkg::WEIGHT_W-1:0]        w1;
   logic [tgme_pkg::WEIGHT_W-1:0]        w2;
   logic [tgme_pkg::WEIGHT_W-1:0]        w3;
   logic [tgme_pkg::WEIGHT_W:0]          w23;

   tgme_pkg::term_cfg_type               cfg1;
   tgme_pkg::term_cfg_type               cfg2;
   tgme_pkg::term_cfg_type               cfg3;
   logic [tgme_pkg::DENS_W-1:0]          g1;
   logic [tgme_pkg::DENS_W-1:0]          g2;
   logic [tgme_pkg::DENS_W-1:0]          g3;

   logic                                 adv;
   logic [LAST:0]                        vld_ff;
   logic [tgme_pkg::MIX_W-1:0]           p1_ff;
   logic [tgme_pkg::MIX_W-1:0]           p2_ff;
   logic [tgme_pkg::MIX_W-1:0]           p3_ff;
   logic [tgme_pkg::SUM_W-1:0]           sum_in;
   logic [tgme_pkg::SUM_W-1:0]           rnd_in;
   logic [tgme_pkg::DENS_W-1:0]          density_in;
   logic [tgme_pkg::DENS_W-1:0]          density_ff;
   logic                                 out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_a_ff <= '0;
         width_a_ff  <= tgme_pkg::WIDTH_W'(tgme_pkg::DENS_ONE);
         center_b_ff <= '0;
         width_b_ff  <= tgme_pkg::WIDTH_W'(tgme_pkg::DENS_ONE);
         width_c_ff  <= tgme_pkg::WIDTH_W'(tgme_pkg::DENS_ONE);
         weight_b_ff <= '0;
         weight_c_ff <= '0;
      end else if (csr_we) begin
         unique case (tgme_pkg::csr_reg_type'(csr_index))
            tgme_pkg::REG_CENTER_A: center_a_ff <= tgme_pkg::SAMPLE_W'(csr_wdata);
            tgme_pkg::REG_WIDTH_A:  width_a_ff  <= csr_wdata[tgme_pkg::WIDTH_W-1:0];
            tgme_pkg::REG_CENTER_B: center_b_ff <= tgme_pkg::SAMPLE_W'(csr_wdata);
            tgme_pkg::REG_WIDTH_B:  width_b_ff  <= csr_wdata[tgme_pkg::WIDTH_W-1:0];
            tgme_pkg::REG_WIDTH_C:  width_c_ff  <= csr_wdata[tgme_pkg::WIDTH_W-1:0];
            tgme_pkg::REG_WEIGHT_B: weight_b_ff <= csr_wdata[tgme_pkg::WEIGHT_W-1:0];
            tgme_pkg::REG_WEIGHT_C: weight_c_ff <= csr_wdata[tgme_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign w2  = (weight_b_ff > tgme_pkg::WEIGHT_ONE) ? tgme_pkg::WEIGHT_ONE : weight_b_ff;
   assign w3  = (weight_c_ff > tgme_pkg::WEIGHT_ONE) ? tgme_pkg::WEIGHT_ONE : weight_c_ff;
   assign w23 = {1'b0, w2} + {1'b0, w3};
   assign w1  = (w23 >= {1'b0, tgme_pkg::WEIGHT_ONE}) ? '0
                : tgme_pkg::WEIGHT_W'({1'b0, tgme_pkg::WEIGHT_ONE} - w23);

   assign cfg1.center = center_a_ff;
   assign cfg1.width  = width_a_ff;
   assign cfg2.center = center_b_ff;
   assign cfg2.width  = width_b_ff;
   assign cfg3.center = center_a_ff;
   assign cfg3.width  = width_c_ff;

   // The pipeline moves unless a finished result sits in both the last stage
   // and the output register while the consumer stalls.
   assign adv = !(out_vld_ff && !rsp_if.ready && vld_ff[LAST]);
   assign req_if.ready = adv;

   tgme_term u_term1 (
      .clock  (clock),
      .adv    (adv),
      .sample (req_if.sample),
      .cfg    (cfg1),
      .term   (g1)
   );

   tgme_term u_term2 (
      .clock  (clock),
      .adv    (adv),
      .sample (req_if.sample),
      .cfg    (cfg2),
      .term   (g2)
   );

   tgme_term u_term3 (
      .clock  (clock),
      .adv    (adv),
      .sample (req_if.sample),
      .cfg    (cfg3),
      .term   (g3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_if.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= tgme_pkg::MIX_W'(w1) * tgme_pkg::MIX_W'(g1);
         p2_ff <= tgme_pkg::MIX_W'(w2) * tgme_pkg::MIX_W'(g2);
         p3_ff <= tgme_pkg::MIX_W'(w3) * tgme_pkg::MIX_W'(g3);
      end
   end

   assign sum_in = tgme_pkg::SUM_W'(p1_ff) + tgme_pkg::SUM_W'(p2_ff)
                 + tgme_pkg::SUM_W'(p3_ff);
   assign rnd_in = (sum_in + tgme_pkg::MIX_RND) >> tgme_pkg::W_SH;
   assign density_in = (rnd_in > tgme_pkg::SUM_W'(tgme_pkg::DENS_ONE)) ? tgme_pkg::DENS_ONE
                       : tgme_pkg::DENS_W'(rnd_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_if.ready) begin
         out_vld_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_if.ready) begin
         density_ff <= density_in;
      end
   end

   assign rsp_if.valid   = out_vld_ff;
   assign rsp_if.density = density_ff;

   `TGME_ASSERT_NOW(a_density_max, clock, reset, rsp_if.valid, rsp_if.density <= tgme_pkg::DENS_ONE)
   `TGME_ASSERT_NOW(a_weight_sum, clock, reset, 18'(w2) + 18'(w3) < 18'(tgme_pkg::WEIGHT_ONE), 18'(w1) + 18'(w2) + 18'(w3) == 18'(tgme_pkg::WEIGHT_ONE))
   `TGME_ASSERT_NEXT(a_accept_enters, clock, reset, req_if.valid && req_if.ready, vld_ff[0])
   `TGME_ASSERT_NEXT(a_stall_holds, clock, reset, out_vld_ff && !rsp_if.ready && vld_ff[LAST], vld_ff[LAST] && out_vld_ff)

endmodule
`default_nettype wire
